[hdl/pct_pkg.sv]
package pct_pkg;

   // Countdown step taken off the counter on each tick while enabled, if the counter exceeds it
   localparam logic [31:0] TICK_STEP = 32'd10000;

   // Kinds of input word
   typedef enum logic [1:0] {
      ACT_READ   = 2'd0,
      ACT_WRITE  = 2'd1,
      ACT_TICK   = 2'd2,
      ACT_UNUSED = 2'd3
   } action_type;

   // Register byte offsets
   localparam logic [7:0] OFS_LOAD    = 8'h00;
   localparam logic [7:0] OFS_COUNTER = 8'h04;
   localparam logic [7:0] OFS_CONTROL = 8'h08;
   localparam logic [7:0] OFS_STATUS  = 8'h0c;

   // CONTROL register bit positions
   localparam int CTL_ENABLE_BIT   = 0;
   localparam int CTL_RELOAD_BIT   = 1;
   localparam int CTL_IRQ_EN_BIT   = 2;
   localparam int CTL_PRESCALE_LSB = 8;
   localparam int CTL_PRESCALE_MSB = 15;

endpackage

[hdl/private_countdown_timer.sv]
// Register-mapped countdown timer. Each request word is a bus read, a bus write, one timer
// tick or an unused action, and each produces exactly one response word carrying read data,
// an access flag and the irq level after the word. A request is accepted in every cycle
// while the response register is empty or being taken; the response appears in the cycle
// after acceptance, from the single register stage holding the timer state and response.
// While a response is stalled, req_stall is held high. Registers: LOAD 0x00 (write-only,
// also sets the counter), COUNTER 0x04, CONTROL 0x08 (enable, auto-reload, irq enable,
// prescale stored but unused), STATUS 0x0c (write one to clear). The irq line is only
// refreshed on expiry and on a STATUS write.
module private_countdown_timer
   import pct_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_action,
   input  logic [7:0]  req_offset,
   input  logic [31:0] req_write_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_read_data,
   output logic        rsp_access_ok,
   output logic        rsp_irq_level
);

   logic        run_enable_ff, run_enable_in;
   logic        reload_mode_ff, reload_mode_in;
   logic        interrupt_enable_ff, interrupt_enable_in;
   logic [7:0]  prescale_value_ff, prescale_value_in;
   logic [31:0] reload_value_ff, reload_value_in;
   logic [31:0] count_value_ff, count_value_in;
   logic        event_flag_ff, event_flag_in;
   logic        irq_out_ff, irq_out_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_read_data_ff, rsp_read_data_in;
   logic        rsp_access_ok_ff, rsp_access_ok_in;

   logic        req_take;
   action_type  act;

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign req_take  = req_valid & ~req_stall;
   assign act       = action_type'(req_action);

   // Next state and response for the incoming word
   always_comb begin
      run_enable_in       = run_enable_ff;
      reload_mode_in      = reload_mode_ff;
      interrupt_enable_in = interrupt_enable_ff;
      prescale_value_in   = prescale_value_ff;
      reload_value_in     = reload_value_ff;
      count_value_in      = count_value_ff;
      event_flag_in       = event_flag_ff;
      irq_out_in          = irq_out_ff;
      rsp_read_data_in    = 32'd0;
      rsp_access_ok_in    = 1'b0;

      unique case (act)
         ACT_READ: begin
            unique case (req_offset)
               OFS_COUNTER: begin
                  rsp_read_data_in = count_value_ff;
                  rsp_access_ok_in = 1'b1;
               end
               OFS_CONTROL: begin
                  rsp_read_data_in[CTL_ENABLE_BIT] = run_enable_ff;
                  rsp_read_data_in[CTL_RELOAD_BIT] = reload_mode_ff;
                  rsp_read_data_in[CTL_IRQ_EN_BIT] = interrupt_enable_ff;
                  rsp_read_data_in[CTL_PRESCALE_MSB:CTL_PRESCALE_LSB] = prescale_value_ff;
                  rsp_access_ok_in = 1'b1;
               end
               OFS_STATUS: begin
                  rsp_read_data_in[0] = event_flag_ff;
                  rsp_access_ok_in    = 1'b1;
               end
               default: begin
                  rsp_access_ok_in = 1'b0;
               end
            endcase
         end
         ACT_WRITE: begin
            unique case (req_offset)
               OFS_LOAD: begin
                  reload_value_in  = req_write_data;
                  count_value_in   = req_write_data;
                  rsp_access_ok_in = 1'b1;
               end
               OFS_COUNTER: begin
                  count_value_in   = req_write_data;
                  rsp_access_ok_in = 1'b1;
               end
               OFS_CONTROL: begin
                  run_enable_in       = req_write_data[CTL_ENABLE_BIT];
                  reload_mode_in      = req_write_data[CTL_RELOAD_BIT];
                  interrupt_enable_in = req_write_data[CTL_IRQ_EN_BIT];
                  prescale_value_in   = req_write_data[CTL_PRESCALE_MSB:CTL_PRESCALE_LSB];
                  // enabling edge with an empty counter in auto-reload
                  if (!run_enable_ff && req_write_data[CTL_ENABLE_BIT] &&
                      (count_value_ff == 32'd0) && req_write_data[CTL_RELOAD_BIT]) begin
                     count_value_in = reload_value_ff;
                  end
                  rsp_access_ok_in = 1'b1;
               end
               OFS_STATUS: begin
                  if (req_write_data[0]) begin
                     event_flag_in = 1'b0;
                  end
                  irq_out_in       = interrupt_enable_ff & event_flag_in;
                  rsp_access_ok_in = 1'b1;
               end
               default: begin
                  rsp_access_ok_in = 1'b0;
               end
            endcase
         end
         ACT_TICK: begin
            rsp_access_ok_in = 1'b1;
            if (run_enable_ff) begin
               if (count_value_ff > TICK_STEP) begin
                  count_value_in = count_value_ff - TICK_STEP;
               end else begin
                  // expiry
                  if (reload_mode_ff) begin
                     count_value_in = reload_value_ff;
                  end else begin
                     count_value_in = 32'd0;
                     run_enable_in  = 1'b0;
                  end
                  event_flag_in = 1'b1;
                  irq_out_in    = interrupt_enable_ff;
               end
            end
         end
         ACT_UNUSED: begin
            rsp_access_ok_in = 1'b0;
         end
      endcase
   end

   // Response register occupancy
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_take) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         run_enable_ff       <= 1'b0;
         reload_mode_ff      <= 1'b0;
         interrupt_enable_ff <= 1'b0;
         prescale_value_ff   <= 8'd0;
         reload_value_ff     <= 32'd0;
         count_value_ff      <= 32'd0;
         event_flag_ff       <= 1'b0;
         irq_out_ff          <= 1'b0;
         rsp_valid_ff        <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_take) begin
            run_enable_ff       <= run_enable_in;
            reload_mode_ff      <= reload_mode_in;
            interrupt_enable_ff <= interrupt_enable_in;
            prescale_value_ff   <= prescale_value_in;
            reload_value_ff     <= reload_value_in;
            count_value_ff      <= count_value_in;
            event_flag_ff       <= event_flag_in;
            irq_out_ff          <= irq_out_in;
         end
      end
   end

   // Response payload, no reset needed
   always_ff @(posedge clock) begin
      if (req_take) begin
         rsp_read_data_ff <= rsp_read_data_in;
         rsp_access_ok_ff <= rsp_access_ok_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_data = rsp_read_data_ff;
   assign rsp_access_ok = rsp_access_ok_ff;
   assign rsp_irq_level = irq_out_ff;

endmodule

[hdl/pct_checker.sv]
module pct_checker
   import pct_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic [1:0]  req_action,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [31:0] rsp_read_data,
   input logic        rsp_access_ok,
   input logic        rsp_irq_level
);

   logic req_take;
   assign req_take = req_valid & ~req_stall;

   // stalled response word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_read_data) &&
      $stable(rsp_access_ok) && $stable(rsp_irq_level))
      else $error("stalled response word changed");

   // every accepted word yields a response next cycle
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      req_take |=> rsp_valid)
      else $error("accepted word produced no response");

   // writes and ticks return no read data
   a_no_data: assert property (@(posedge clock) disable iff (reset)
      req_take && (req_action == ACT_WRITE || req_action == ACT_TICK)
      |=> rsp_read_data == 32'd0)
      else $error("write or tick returned read data");

   // ticks always succeed
   a_tick_ok: assert property (@(posedge clock) disable iff (reset)
      req_take && req_action == ACT_TICK |=> rsp_access_ok)
      else $error("tick flagged as invalid");

   // failed access reads as zero
   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_access_ok |-> rsp_read_data == 32'd0)
      else $error("invalid access returned data");

endmodule

bind private_countdown_timer pct_checker u_pct_checker (.*);

[tb/private_countdown_timer_tb.sv]
module private_countdown_timer_tb;
   import pct_pkg::*;

   localparam int CYCLE_LIMIT   = 200000;
   localparam int RANDOM_WORDS  = 300;   // per idling phase
   localparam int DIRECTED_ROWS = 26;

   // Expected response word
   typedef struct packed {
      logic [31:0] read_data;
      logic        access_ok;
      logic        irq_level;
   } timer_rsp_type;

   // One directed stimulus row; fixed rows carry a hand-written response
   typedef struct {
      action_type  action;
      logic [7:0]  offset;
      logic [31:0] write_data;
      bit          fixed;
      logic [31:0] read_data;
      logic        access_ok;
      logic        irq_level;
   } directed_row_type;

   typedef struct {
      bit            fixed;
      timer_rsp_type rsp;
   } fixed_rsp_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [1:0]  req_action;
   logic [7:0]  req_offset;
   logic [31:0] req_write_data;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [31:0] rsp_read_data;
   logic        rsp_access_ok;
   logic        rsp_irq_level;

   // Timer state as the testbench sees it
   logic        tm_run;
   logic        tm_reload_mode;
   logic        tm_irq_en;
   logic [7:0]  tm_prescale;
   logic [31:0] tm_reload;
   logic [31:0] tm_count;
   logic        tm_event;
   logic        tm_irq;

   timer_rsp_type    pending_rsp[$];
   fixed_rsp_type    fixed_rsp_q[$];
   directed_row_type directed_rows[DIRECTED_ROWS];
   logic [7:0]       reg_offsets[4];

   int unsigned send_idle_pct;
   int unsigned rsp_stall_pct;
   int unsigned mismatch_count;
   int unsigned cycle_count;

   private_countdown_timer dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_action     (req_action),
      .req_offset     (req_offset),
      .req_write_data (req_write_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_read_data  (rsp_read_data),
      .rsp_access_ok  (rsp_access_ok),
      .rsp_irq_level  (rsp_irq_level)
   );

   initial clock = 1'b0;
   always #4 clock = ~clock;

   // Apply one word to the timer state and return the response it gives
   function automatic timer_rsp_type predict_timer_word(action_type act, logic [7:0] ofs,
                                                        logic [31:0] wd);
      timer_rsp_type r;
      logic          was_running;
      r = '0;
      case (act)
         ACT_READ: begin
            r.access_ok = 1'b1;
            case (ofs)
               OFS_COUNTER: r.read_data = tm_count;
               OFS_CONTROL: begin
                  r.read_data[CTL_ENABLE_BIT] = tm_run;
                  r.read_data[CTL_RELOAD_BIT] = tm_reload_mode;
                  r.read_data[CTL_IRQ_EN_BIT] = tm_irq_en;
                  r.read_data[CTL_PRESCALE_MSB:CTL_PRESCALE_LSB] = tm_prescale;
               end
               OFS_STATUS: r.read_data[0] = tm_event;
               default: r.access_ok = 1'b0;
            endcase
         end
         ACT_WRITE: begin
            r.access_ok = 1'b1;
            case (ofs)
               OFS_LOAD: begin
                  tm_reload = wd;
                  tm_count  = wd;
               end
               OFS_COUNTER: tm_count = wd;
               OFS_CONTROL: begin
                  was_running    = tm_run;
                  tm_run         = wd[CTL_ENABLE_BIT];
                  tm_reload_mode = wd[CTL_RELOAD_BIT];
                  tm_irq_en      = wd[CTL_IRQ_EN_BIT];
                  tm_prescale    = wd[CTL_PRESCALE_MSB:CTL_PRESCALE_LSB];
                  // enabling edge with an empty counter reloads it
                  if (!was_running && tm_run && tm_count == 32'd0 && tm_reload_mode)
                     tm_count = tm_reload;
               end
               OFS_STATUS: begin
                  if (wd[0])
                     tm_event = 1'b0;
                  tm_irq = tm_irq_en & tm_event;
               end
               default: r.access_ok = 1'b0;
            endcase
         end
         ACT_TICK: begin
            r.access_ok = 1'b1;
            if (tm_run) begin
               if (tm_count > TICK_STEP) begin
                  tm_count = tm_count - TICK_STEP;
               end else begin
                  if (tm_reload_mode) begin
                     tm_count = tm_reload;
                  end else begin
                     tm_count = 32'd0;
                     tm_run   = 1'b0;
                  end
                  tm_event = 1'b1;
                  tm_irq   = tm_irq_en & tm_event;
               end
            end
         end
         default: ;
      endcase
      r.irq_level = tm_irq;
      return r;
   endfunction

   // Drive one request word and hold it until the timer takes it
   task automatic send_word(action_type act, logic [7:0] ofs, logic [31:0] wd,
                            fixed_rsp_type fixed);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      fixed_rsp_q.push_back(fixed);
      req_valid      <= 1'b1;
      req_action     <= act;
      req_offset     <= ofs;
      req_write_data <= wd;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
   endtask

   // Random word: mostly register traffic and ticks with counts that expire soon
   task automatic send_random_word();
      int unsigned   pick;
      action_type    act;
      logic [7:0]    ofs;
      logic [31:0]   wd;
      fixed_rsp_type none;
      none = '{fixed: 1'b0, rsp: '0};
      pick = $urandom_range(0, 99);
      ofs  = reg_offsets[$urandom_range(0, 3)];
      wd   = $urandom;
      if (pick < 38) begin
         act = ACT_TICK;
      end else if (pick < 58) begin
         act = ACT_READ;
      end else if (pick < 86) begin
         act = ACT_WRITE;
         if (ofs == OFS_LOAD || ofs == OFS_COUNTER) begin
            case ($urandom_range(0, 7))
               0: ;
               1: wd = TICK_STEP - 1 + $urandom_range(0, 2);
               default: wd = $urandom_range(0, 6 * TICK_STEP);
            endcase
         end else if (ofs == OFS_CONTROL && $urandom_range(0, 3) != 0) begin
            wd[CTL_ENABLE_BIT] = 1'b1;
         end
      end else if (pick < 94) begin
         act = ($urandom_range(0, 1) != 0) ? ACT_WRITE : ACT_READ;
         ofs = 8'($urandom_range(0, 255));
      end else begin
         act = ACT_UNUSED;
         ofs = 8'($urandom_range(0, 255));
      end
      send_word(act, ofs, wd, none);
   endtask

   // Receiver back-pressure
   always @(posedge clock) begin
      if (reset)
         rsp_stall <= 1'b0;
      else
         rsp_stall <= ($urandom_range(0, 99) < rsp_stall_pct);
   end

   // Predict on each accepted request, check each accepted response
   always @(posedge clock) begin
      timer_rsp_type got;
      timer_rsp_type want;
      timer_rsp_type predicted;
      fixed_rsp_type fixed;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{read_data: rsp_read_data, access_ok: rsp_access_ok,
                 irq_level: rsp_irq_level};
         if (pending_rsp.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected response word: rd=%h ok=%b irq=%b",
                        got.read_data, got.access_ok, got.irq_level);
         end else begin
            want = pending_rsp.pop_front();
            if (got.read_data !== want.read_data || got.access_ok !== want.access_ok ||
                got.irq_level !== want.irq_level) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: expected rd=%h ok=%b irq=%b, got rd=%h ok=%b irq=%b",
                           want.read_data, want.access_ok, want.irq_level,
                           got.read_data, got.access_ok, got.irq_level);
            end
         end
      end
      if (!reset && req_valid && !req_stall) begin
         predicted = predict_timer_word(action_type'(req_action), req_offset,
                                        req_write_data);
         fixed = fixed_rsp_q.pop_front();
         pending_rsp.push_back(fixed.fixed ? fixed.rsp : predicted);
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin
      fixed_rsp_type fixed;
      reg_offsets = '{OFS_LOAD, OFS_COUNTER, OFS_CONTROL, OFS_STATUS};
      // action, offset, data, fixed, read_data, access_ok, irq
      directed_rows = '{
         '{ACT_READ,   OFS_COUNTER, 32'd0,          1'b1, 32'd0,     1'b1, 1'b0},
         '{ACT_READ,   OFS_CONTROL, 32'd0,          1'b1, 32'd0,     1'b1, 1'b0},
         '{ACT_READ,   OFS_STATUS,  32'd0,          1'b1, 32'd0,     1'b1, 1'b0},
         // LOAD is write-only
         '{ACT_READ,   OFS_LOAD,    32'hffffffff,   1'b1, 32'd0,     1'b0, 1'b0},
         '{ACT_READ,   8'hff,       32'd0,          1'b1, 32'd0,     1'b0, 1'b0},
         '{ACT_UNUSED, 8'hff,       32'hffffffff,   1'b1, 32'd0,     1'b0, 1'b0},
         // tick while stopped
         '{ACT_TICK,   OFS_LOAD,    32'd0,          1'b1, 32'd0,     1'b1, 1'b0},
         '{ACT_WRITE,  8'hff,       32'hffffffff,   1'b1, 32'd0,     1'b0, 1'b0},
         '{ACT_WRITE,  OFS_LOAD,    32'd25000,      1'b1, 32'd0,     1'b1, 1'b0},
         // enable, auto-reload, irq enable, prescale all ones
         '{ACT_WRITE,  OFS_CONTROL, 32'h0000ff07,   1'b1, 32'd0,     1'b1, 1'b0},
         '{ACT_READ,   OFS_CONTROL, 32'd0,          1'b1, 32'h0000ff07, 1'b1, 1'b0},
         '{ACT_TICK,   OFS_LOAD,    32'd0,          1'b0, 32'd0,     1'b0, 1'b0},
         '{ACT_TICK,   OFS_LOAD,    32'd0,          1'b0, 32'd0,     1'b0, 1'b0},
         // expiry with reload raises irq
         '{ACT_TICK,   OFS_LOAD,    32'd0,          1'b1, 32'd0,     1'b1, 1'b1},
         '{ACT_READ,   OFS_STATUS,  32'd0,          1'b1, 32'd1,     1'b1, 1'b1},
         '{ACT_READ,   OFS_COUNTER, 32'd0,          1'b1, 32'd25000, 1'b1, 1'b1},
         // control write leaves the irq line alone
         '{ACT_WRITE,  OFS_CONTROL, 32'd0,          1'b1, 32'd0,     1'b1, 1'b1},
         // status write without the clear bit still refreshes the line
         '{ACT_WRITE,  OFS_STATUS,  32'd0,          1'b1, 32'd0,     1'b1, 1'b0},
         '{ACT_WRITE,  OFS_COUNTER, 32'd0,          1'b1, 32'd0,     1'b1, 1'b0},
         // enabling edge on an empty counter with auto-reload
         '{ACT_WRITE,  OFS_CONTROL, 32'h00000003,   1'b1, 32'd0,     1'b1, 1'b0},
         '{ACT_READ,   OFS_COUNTER, 32'd0,          1'b1, 32'd25000, 1'b1, 1'b0},
         '{ACT_WRITE,  OFS_STATUS,  32'hffffffff,   1'b1, 32'd0,     1'b1, 1'b0},
         '{ACT_WRITE,  OFS_CONTROL, 32'h00000005,   1'b1, 32'd0,     1'b1, 1'b0},
         '{ACT_WRITE,  OFS_COUNTER, TICK_STEP,      1'b1, 32'd0,     1'b1, 1'b0},
         // count equal to the step expires; no reload so the timer stops
         '{ACT_TICK,   OFS_LOAD,    32'd0,          1'b1, 32'd0,     1'b1, 1'b1},
         '{ACT_READ,   OFS_CONTROL, 32'd0,          1'b1, 32'h00000004, 1'b1, 1'b1}
      };

      tm_run = 1'b0;
      tm_reload_mode = 1'b0;
      tm_irq_en = 1'b0;
      tm_prescale = '0;
      tm_reload = '0;
      tm_count = '0;
      tm_event = 1'b0;
      tm_irq = 1'b0;
      send_idle_pct = 10;
      rsp_stall_pct = 86;

      reset          <= 1'b1;
      req_valid      <= 1'b0;
      req_action     <= ACT_READ;
      req_offset     <= OFS_LOAD;
      req_write_data <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed table
      foreach (directed_rows[i]) begin
         fixed.fixed = directed_rows[i].fixed;
         fixed.rsp   = '{read_data: directed_rows[i].read_data,
                         access_ok: directed_rows[i].access_ok,
                         irq_level: directed_rows[i].irq_level};
         send_word(directed_rows[i].action, directed_rows[i].offset,
                   directed_rows[i].write_data, fixed);
      end

      // Random words in three idling phases
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin send_idle_pct = 10; rsp_stall_pct = 86; end
            1: begin send_idle_pct = 86; rsp_stall_pct = 10; end
            default: begin send_idle_pct = 0; rsp_stall_pct = 0; end
         endcase
         repeat (RANDOM_WORDS)
            send_random_word();
      end
      req_valid <= 1'b0;

      // Drain outstanding responses
      do
         @(posedge clock);
      while (pending_rsp.size() != 0);
      repeat (4) @(posedge clock);

      if (mismatch_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

[sim.f]
hdl/pct_pkg.sv
hdl/private_countdown_timer.sv
hdl/pct_checker.sv
tb/private_countdown_timer_tb.sv
